// File: sv/tzpm_pkg.sv
package tzpm_pkg;

	localparam int CMD_W  = 2;
	localparam int SAMP_W = 16;
	localparam int CFG_W  = 12;
	localparam int SLOT_W = 5;

	localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HIDE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNHIDE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BADVERT = 2'd2;
	localparam logic [1:0] ST_BADSLOT = 2'd3;

	localparam logic CFG_WIDTH_IDX  = 1'b0;
	localparam logic CFG_HEIGHT_IDX = 1'b1;

	// token passed down the cell chain
	typedef struct packed {
		logic              hid;
		logic              fill_done;
		logic [SLOT_W-1:0] fill_slot;
	} chain_t;

endpackage

// File: sv/tzpm_cell.sv
// one zone slot: holds its triangle and tests the pixel in flight
module tzpm_cell #(
	parameter int CB  = 11,
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [tzpm_pkg::CMD_W-1:0] cmd,
	input  logic [CB-1:0]          px,
	input  logic [CB-1:0]          py,
	input  logic [3*CB-1:0]        wr_xs,
	input  logic [3*CB-1:0]        wr_ys,
	input  logic                   hide_ok,
	input  logic                   clr,
	input  logic                   step,
	input  tzpm_pkg::chain_t       tok_in,
	output tzpm_pkg::chain_t       tok_out,
	output logic                   used
);
	localparam int DW = CB + 2;
	localparam int PW = 2 * DW + 1;

	logic           used_q;
	logic [3*CB-1:0] xs_q, ys_q;
	tzpm_pkg::chain_t tok_q;
	logic signed [DW-1:0] x1, x2, x3, y1, y2, y3, sx, sy;
	logic in_box, e1, e2, e3, hit;

	assign used = used_q;
	assign tok_out = tok_q;

	assign x1 = DW'(xs_q[CB-1:0]);
	assign x2 = DW'(xs_q[2*CB-1:CB]);
	assign x3 = DW'(xs_q[3*CB-1:2*CB]);
	assign y1 = DW'(ys_q[CB-1:0]);
	assign y2 = DW'(ys_q[2*CB-1:CB]);
	assign y3 = DW'(ys_q[3*CB-1:2*CB]);
	assign sx = DW'(px);
	assign sy = DW'(py);

	function automatic logic edge_ok(input logic signed [DW-1:0] ax, ay, bx, by, rx, ry,
		qx, qy);
		logic signed [PW-1:0] dp, dr;
		logic zp, zr;
		begin
			dp = PW'(qy - ay) * PW'(bx - ax) - PW'(by - ay) * PW'(qx - ax);
			dr = PW'(ry - ay) * PW'(bx - ax) - PW'(by - ay) * PW'(rx - ax);
			zp = (dp == '0);
			zr = (dr == '0);
			edge_ok = (bx == ax) || zp || zr || (dp[PW-1] == dr[PW-1]);
		end
	endfunction

	always_comb begin
		in_box = (sx >= x1) && (sx <= x3)
			&& !((sy < y1) && (sy < y2) && (sy < y3))
			&& !((sy > y1) && (sy > y2) && (sy > y3));
		e1 = edge_ok(x1, y1, x2, y2, x3, y3, sx, sy);
		e2 = edge_ok(x2, y2, x3, y3, x1, y1, sx, sy);
		e3 = edge_ok(x1, y1, x3, y3, x2, y2, sx, sy);
		hit = used_q && in_box && e1 && e2 && e3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= '0;
		end else if (clr) begin
			used_q <= 1'b0;
		end else if (step) begin
			tok_q.hid <= tok_in.hid | (cmd == tzpm_pkg::CMD_PIXEL && hit);
			tok_q.fill_done <= tok_in.fill_done | !used_q;
			tok_q.fill_slot <= tok_in.fill_done ? tok_in.fill_slot
				: tzpm_pkg::SLOT_W'(IDX);
			if (hide_ok && !tok_in.fill_done && !used_q) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && hide_ok && !tok_in.fill_done && !used_q) begin
			xs_q <= wr_xs;
			ys_q <= wr_ys;
		end
	end

	logic unused_start;
	assign unused_start = start;
endmodule

// File: sv/triangle_zone_pixel_mask_unit.sv
// triangle zone pixel mask: a chain of MAX_ZONE_COUNT cells, one per zone slot, each
// holding a stored triangle. an item is taken, then a token walks the chain one cell
// per clock, collecting the pixel hit flag and the first free slot; a hide writes
// its x-ordered triangle into that slot as the token passes. a pixel or hide item
// passes through the take, then the walk along the whole cell chain, then a state
// with the result on offer, before the next take; unhide and unused commands go
// straight from the take to the result on offer. the result sits in an output
// register and the next item is taken in the cycle after it has been handed over.
module triangle_zone_pixel_mask_unit #(
	parameter int MAX_ZONE_COUNT = 20,
	parameter int COORD_BITS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd, pos_x, pos_y, luma_in, cb_in, cr_in, vert_bx, vert_by, vert_cx,
	// vert_cy, zone_slot, zero pad
	input  logic [((2 + 6*COORD_BITS + 48 + 5 + 7) / 8) * 8 - 1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// luma_out, cb_out, cr_out, hidden, status, slot_written, zero pad
	output logic [63:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);
	localparam int CB = COORD_BITS;
	localparam int CW = tzpm_pkg::CMD_W;
	localparam int SW = tzpm_pkg::SLOT_W;
	localparam int N  = MAX_ZONE_COUNT;
	localparam int NW = (N > 1) ? $clog2(N + 1) : 1;
	localparam int OFS_X  = CW;
	localparam int OFS_Y  = OFS_X + CB;
	localparam int OFS_L  = OFS_Y + CB;
	localparam int OFS_CB = OFS_L + 16;
	localparam int OFS_CR = OFS_CB + 16;
	localparam int OFS_BX = OFS_CR + 16;
	localparam int OFS_BY = OFS_BX + CB;
	localparam int OFS_CX = OFS_BY + CB;
	localparam int OFS_CY = OFS_CX + CB;
	localparam int OFS_SL = OFS_CY + CB;

	typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;
	state_t state_q;

	logic [11:0] fw_q, fh_q;
	logic [NW-1:0] cnt_q;

	// item held while it walks the chain
	logic [CW-1:0] cmd_q;
	logic [CB-1:0] px_q, py_q;
	logic [15:0] l_q, cb_q, cr_q;
	logic [3*CB-1:0] xs_q, ys_q;
	logic hide_ok_q, badv_q;
	logic [SW-1:0] slot_q;

	logic [63:0] out_q;

	// unpacked fields
	logic [CW-1:0] i_cmd;
	logic [CB-1:0] ax, ay, bx, by, cx, cy;
	logic [SW-1:0] i_slot;
	logic [CB-1:0] o0x, o0y, o1x, o1y, o2x, o2y;
	logic badv, take;

	assign i_cmd  = s_tdata[CW-1:0];
	assign ax     = s_tdata[OFS_X +: CB];
	assign ay     = s_tdata[OFS_Y +: CB];
	assign bx     = s_tdata[OFS_BX +: CB];
	assign by     = s_tdata[OFS_BY +: CB];
	assign cx     = s_tdata[OFS_CX +: CB];
	assign cy     = s_tdata[OFS_CY +: CB];
	assign i_slot = s_tdata[OFS_SL +: SW];

	assign s_tready = (state_q == IDLE);
	assign take = s_tvalid && s_tready;
	assign m_tvalid = (state_q == DONE);
	assign m_tdata = out_q;

	// vertex range check against the frame
	assign badv = (12'(ax) >= fw_q) || (12'(bx) >= fw_q) || (12'(cx) >= fw_q)
		|| (12'(ay) >= fh_q) || (12'(by) >= fh_q) || (12'(cy) >= fh_q);

	// order vertices by x with the fixed comparison chain
	always_comb begin
		if (ax < bx) begin
			if (bx < cx) begin
				{o0x, o0y, o1x, o1y, o2x, o2y} = {ax, ay, bx, by, cx, cy};
			end else if (cx < ax) begin
				{o0x, o0y, o1x, o1y, o2x, o2y} = {cx, cy, ax, ay, bx, by};
			end else begin
				{o0x, o0y, o1x, o1y, o2x, o2y} = {ax, ay, cx, cy, bx, by};
			end
		end else if (bx < cx) begin
			if (cx < ax) begin
				{o0x, o0y, o1x, o1y, o2x, o2y} = {bx, by, cx, cy, ax, ay};
			end else begin
				{o0x, o0y, o1x, o1y, o2x, o2y} = {bx, by, ax, ay, cx, cy};
			end
		end else begin
			{o0x, o0y, o1x, o1y, o2x, o2y} = {cx, cy, bx, by, ax, ay};
		end
	end

	// chain of cells
	tzpm_pkg::chain_t tok [N+1];
	logic [N-1:0] used_v;
	logic [N-1:0] clr_v;
	logic step;
	assign tok[0] = '0;
	assign step = (state_q == RUN);

	for (genvar g = 0; g < N; g++) begin : g_cell
		assign clr_v[g] = take && (i_cmd == tzpm_pkg::CMD_UNHIDE)
			&& (i_slot == SW'(g));
		tzpm_cell #(.CB(CB), .IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .start(take), .cmd(cmd_q),
			.px(px_q), .py(py_q), .wr_xs(xs_q), .wr_ys(ys_q),
			.hide_ok(hide_ok_q && (cnt_q == NW'(g))), .clr(clr_v[g]),
			.step(step && (cnt_q == NW'(g))),
			.tok_in(tok[g]), .tok_out(tok[g+1]), .used(used_v[g])
		);
	end

	logic unused_used;
	assign unused_used = ^used_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= '0;
			fh_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == tzpm_pkg::CFG_WIDTH_IDX) fw_q <= cfg_data;
			else fh_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q  <= i_cmd;
			px_q   <= ax;
			py_q   <= ay;
			l_q    <= s_tdata[OFS_L +: 16];
			cb_q   <= s_tdata[OFS_CB +: 16];
			cr_q   <= s_tdata[OFS_CR +: 16];
			xs_q   <= {o2x, o1x, o0x};
			ys_q   <= {o2y, o1y, o0y};
			badv_q <= badv;
			slot_q <= i_slot;
			hide_ok_q <= (i_cmd == tzpm_pkg::CMD_HIDE) && !badv;
		end
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			out_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (take) begin
						cnt_q <= '0;
						if (i_cmd == tzpm_pkg::CMD_PIXEL || i_cmd == tzpm_pkg::CMD_HIDE) begin
							state_q <= RUN;
						end else begin
							out_q <= {13'd0,
								(i_cmd == tzpm_pkg::CMD_UNHIDE && i_slot >= SW'(N))
								? tzpm_pkg::ST_BADSLOT : tzpm_pkg::ST_OK, 49'd0};
							state_q <= DONE;
						end
					end
				end
				RUN: begin
					if (cnt_q == NW'(N)) begin
						if (cmd_q == tzpm_pkg::CMD_PIXEL) begin
							out_q <= {13'd0, tzpm_pkg::ST_OK, tok[N].hid,
								tok[N].hid ? 48'd0 : {cr_q, cb_q, l_q}};
						end else if (badv_q) begin
							out_q <= {13'd0, tzpm_pkg::ST_BADVERT, 49'd0};
						end else if (!tok[N].fill_done) begin
							out_q <= {13'd0, tzpm_pkg::ST_FULL, 49'd0};
						end else begin
							out_q <= {8'd0, tok[N].fill_slot, tzpm_pkg::ST_OK, 49'd0};
						end
						state_q <= DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DONE: begin
					if (m_tready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	logic unused_slot;
	assign unused_slot = ^slot_q;
endmodule
